// ===== hw/rtl/utf8sd_pkg.sv =====
// shared types and constants for the utf-8 stream decoder
package utf8sd_pkg;

   // result queue depth and derived widths
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = PTR_W + 1;

   // substitution character for a malformed sequence
   localparam logic [31:0] CARET_CODE = 32'h0000_005E;

   // continuation byte pattern (10xxxxxx)
   localparam logic [1:0] CONT_TAG = 2'b10;

   // one result item
   typedef struct packed {
      logic [31:0] code_point;
      logic        bad_sequence;
      logic        last_of_run;
   } result_type;

   // results produced by one input item
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } decode_type;

   // count of leading one bits of a lead byte whose top bit is set (1..8)
   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] k;
      k = 4'd8;
      for (int i = 0; i < 7; i++) begin
         if (!b[6-i] && k == 4'd8) begin
            k = 4'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

// ===== hw/rtl/utf8sd_decode.sv =====
// per-byte decode logic with the sequence state registers
module utf8sd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             byte_in,
   output utf8sd_pkg::decode_type dec
);

   logic [2:0]  pending_ff;
   logic [2:0]  pending_in;
   logic [31:0] partial_ff;
   logic [31:0] partial_in;

   logic        is_cont;
   logic        bad;
   logic [3:0]  k;
   logic [7:0]  lead_val;
   logic        lead_emit;
   logic [31:0] lead_cp;
   logic [31:0] shifted;

   // lead byte path
   always_comb begin
      k        = utf8sd_pkg::lead_ones(byte_in);
      lead_val = byte_in & (8'hFF >> k);
      if (!byte_in[7]) begin
         lead_emit = 1'b1;
         lead_cp   = {24'd0, byte_in};
      end else begin
         lead_emit = (k == 4'd1);
         lead_cp   = {24'd0, lead_val};
      end
   end

   // continuation path and result selection
   always_comb begin
      is_cont    = (byte_in[7:6] == utf8sd_pkg::CONT_TAG);
      shifted    = {partial_ff[25:0], byte_in[5:0]};
      bad        = 1'b0;
      pending_in = pending_ff;
      partial_in = partial_ff;
      dec        = '0;
      if (pending_ff != 3'd0 && is_cont) begin
         partial_in = shifted;
         pending_in = pending_ff - 3'd1;
         if (pending_ff == 3'd1) begin
            dec.num          = 2'd1;
            dec.first        = '{code_point: shifted, bad_sequence: 1'b0, last_of_run: 1'b1};
         end
      end else begin
         bad = (pending_ff != 3'd0);
         if (!byte_in[7]) begin
            pending_in = 3'd0;
         end else begin
            partial_in = {24'd0, lead_val};
            pending_in = 3'(k - 4'd1);
         end
         if (bad) begin
            dec.first = '{code_point: utf8sd_pkg::CARET_CODE, bad_sequence: 1'b1,
                          last_of_run: !lead_emit};
            dec.second = '{code_point: lead_cp, bad_sequence: 1'b0, last_of_run: 1'b1};
            dec.num    = lead_emit ? 2'd2 : 2'd1;
         end else begin
            dec.first = '{code_point: lead_cp, bad_sequence: 1'b0, last_of_run: 1'b1};
            dec.num   = lead_emit ? 2'd1 : 2'd0;
         end
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
         partial_ff <= 32'd0;
      end else if (fire) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// ===== hw/rtl/utf8sd_queue.sv =====
// small result queue taking up to two items per cycle
module utf8sd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  utf8sd_pkg::decode_type       dec,
   input  logic                         push,
   output logic                         room,
   output logic                         out_valid,
   input  logic                         out_stall,
   output utf8sd_pkg::result_type       out_item
);

   utf8sd_pkg::result_type entry_ff [utf8sd_pkg::QUEUE_DEPTH];

   logic [utf8sd_pkg::PTR_W-1:0] wr_ff;
   logic [utf8sd_pkg::PTR_W-1:0] wr_in;
   logic [utf8sd_pkg::PTR_W-1:0] wr_next;
   logic [utf8sd_pkg::PTR_W-1:0] rd_ff;
   logic [utf8sd_pkg::PTR_W-1:0] rd_in;
   logic [utf8sd_pkg::CNT_W-1:0] cnt_ff;
   logic [utf8sd_pkg::CNT_W-1:0] cnt_in;
   logic [utf8sd_pkg::CNT_W-1:0] add;
   logic                         pop;

   // occupancy and pointers
   always_comb begin
      out_valid = (cnt_ff != '0);
      out_item  = entry_ff[rd_ff];
      pop       = out_valid && !out_stall;
      room      = (cnt_ff <= utf8sd_pkg::CNT_W'(utf8sd_pkg::QUEUE_DEPTH - 2));
      add       = push ? utf8sd_pkg::CNT_W'(dec.num) : '0;
      wr_next   = wr_ff + utf8sd_pkg::PTR_W'(1);
      wr_in     = wr_ff + add[utf8sd_pkg::PTR_W-1:0];
      rd_in     = pop ? rd_ff + utf8sd_pkg::PTR_W'(1) : rd_ff;
      cnt_in    = cnt_ff + add - (pop ? utf8sd_pkg::CNT_W'(1) : '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push && dec.num != 2'd0) begin
         entry_ff[wr_ff] <= dec.first;
      end
      if (push && dec.num == 2'd2) begin
         entry_ff[wr_next] <= dec.second;
      end
   end

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// utf-8 stream decoder top level: input register, decode, result queue
// data path: input register, combinational decode, then the result queue
// throughput: one byte per cycle while the queue has room; two results from
//    one byte leave one after the other, and the four-entry queue absorbs them
// reset: synchronous; clears the sequence state (awaiting a lead byte) and
//    empties the input register and the result queue
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_code_point,
   output logic        rsp_bad_sequence,
   output logic        rsp_last_of_run
);

   logic                   in_vld_ff;
   logic                   in_vld_in;
   logic [7:0]             in_byte_ff;
   logic                   room;
   logic                   fire;
   utf8sd_pkg::decode_type dec;
   utf8sd_pkg::result_type head;

   // input register handshake
   always_comb begin
      fire      = in_vld_ff && room;
      req_stall = in_vld_ff && !room;
      in_vld_in = req_stall ? in_vld_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // byte decode
   utf8sd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .byte_in (in_byte_ff),
      .dec     (dec)
   );

   // result queue
   utf8sd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .dec       (dec),
      .push      (fire),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (head)
   );

   assign rsp_code_point   = head.code_point;
   assign rsp_bad_sequence = head.bad_sequence;
   assign rsp_last_of_run  = head.last_of_run;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the utf-8 stream decoder
module testbench;

   localparam int TOTAL_ITEMS = 1400;
   localparam int TAIL_ITEMS  = 150;
   localparam int HOLD_START  = 400;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_WAIT  = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in      = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_code_point;
   logic        rsp_bad_sequence;
   logic        rsp_last_of_run;

   // stimulus and expectation stores
   logic [7:0]             pending_bytes[$];
   utf8sd_pkg::result_type expected_results[$];
   int         total_bytes    = 0;
   int         accepted_count = 0;
   int         mismatches     = 0;
   int         cycle_count    = 0;
   int         send_gap       = 0;
   int         stall_left     = 0;
   logic       long_hold      = 1'b0;

   // decoder state as predicted
   logic [31:0] decode_partial = 32'h0;
   logic [2:0]  decode_pending = 3'd0;

   utf8_stream_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // no idling once the tail of the stream is reached
   function automatic bit idling_allowed();
      return (accepted_count + TAIL_ITEMS) < total_bytes;
   endfunction

   // work out the results caused by one accepted byte
   task automatic predict_byte(input logic [7:0] b);
      utf8sd_pkg::result_type caret_item;
      utf8sd_pkg::result_type value_item;
      bit         caret_seen;
      int         k;
      caret_seen = 1'b0;
      caret_item = '{code_point: utf8sd_pkg::CARET_CODE, bad_sequence: 1'b1,
                     last_of_run: 1'b1};
      // sequence in progress: continuation or break
      if (decode_pending != 3'd0) begin
         if (b[7:6] == utf8sd_pkg::CONT_TAG) begin
            decode_partial = {decode_partial[25:0], b[5:0]};
            decode_pending = decode_pending - 3'd1;
            if (decode_pending == 3'd0) begin
               value_item = '{code_point: decode_partial, bad_sequence: 1'b0,
                              last_of_run: 1'b1};
               expected_results.push_back(value_item);
            end
            return;
         end
         decode_pending = 3'd0;
         caret_seen     = 1'b1;
      end
      // byte taken as a lead byte
      if (!b[7]) begin
         value_item = '{code_point: {24'h0, b}, bad_sequence: 1'b0, last_of_run: 1'b1};
         if (caret_seen) begin
            caret_item.last_of_run = 1'b0;
            expected_results.push_back(caret_item);
         end
         expected_results.push_back(value_item);
         return;
      end
      k = 1;
      while (k < 8 && b[7-k]) k++;
      decode_partial = {24'h0, b} & ((32'd1 << (8 - k)) - 32'd1);
      decode_pending = 3'(k - 1);
      if (decode_pending == 3'd0) begin
         value_item = '{code_point: decode_partial, bad_sequence: 1'b0, last_of_run: 1'b1};
         if (caret_seen) caret_item.last_of_run = 1'b0;
         if (caret_seen) expected_results.push_back(caret_item);
         expected_results.push_back(value_item);
      end else if (caret_seen) begin
         expected_results.push_back(caret_item);
      end
   endtask

   // lead byte announcing k-1 continuation bytes, random low bits
   function automatic logic [7:0] lead_byte(input int k);
      logic [7:0] ones;
      logic [7:0] low;
      ones = 8'hFF << (8 - k);
      low  = (k >= 7) ? 8'h00 : (8'($urandom) & (8'hFF >> (k + 1)));
      return ones | low;
   endfunction

   function automatic logic [7:0] cont_byte();
      return {utf8sd_pkg::CONT_TAG, 6'($urandom)};
   endfunction

   // fill the stimulus queue: directed bytes, then random sequences
   initial begin
      int         choice;
      int         k;
      int         n;
      logic [7:0] b;
      // ascii extremes and lone continuation bytes
      pending_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF};
      // two-byte sequence
      pending_bytes.push_back(8'hC2);
      pending_bytes.push_back(8'hA9);
      // bad continuation that is ascii: caret then the letter
      pending_bytes.push_back(8'hC3);
      pending_bytes.push_back(8'h41);
      // bad continuation that starts a new two-byte sequence
      pending_bytes.push_back(8'hE0);
      pending_bytes.push_back(8'hC3);
      pending_bytes.push_back(8'hA9);
      // eight-ones lead, value wraps past bit 31
      pending_bytes.push_back(8'hFF);
      repeat (7) pending_bytes.push_back(8'hBF);
      // seven-ones lead with six continuations
      pending_bytes.push_back(8'hFE);
      repeat (6) pending_bytes.push_back(8'h80);
      // random part
      while (pending_bytes.size() < TOTAL_ITEMS) begin
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            pending_bytes.push_back(8'($urandom) & 8'h7F);
         end else if (choice < 70) begin
            // well-formed multi-byte sequence
            n = $urandom_range(0, 9);
            k = (n < 4) ? 2 : (n < 7) ? 3 : (n < 9) ? 4 : $urandom_range(5, 8);
            pending_bytes.push_back(lead_byte(k));
            repeat (k - 1) pending_bytes.push_back(cont_byte());
         end else if (choice < 85) begin
            // truncated sequence broken by a non-continuation byte
            k = $urandom_range(2, 8);
            pending_bytes.push_back(lead_byte(k));
            repeat ($urandom_range(0, k - 2)) pending_bytes.push_back(cont_byte());
            do b = 8'($urandom); while (b[7:6] == utf8sd_pkg::CONT_TAG);
            pending_bytes.push_back(b);
         end else begin
            pending_bytes.push_back(8'($urandom));
         end
      end
      total_bytes = pending_bytes.size();
   end

   // reset sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: offers bytes from the queue with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_byte_in);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               if (idling_allowed() && $urandom_range(0, 4) == 0) begin
                  send_gap = $urandom_range(0, 2);
                  req_valid <= 1'b0;
               end else begin
                  req_valid   <= 1'b1;
                  req_byte_in <= pending_bytes.pop_front();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result and drives the stall
   always @(posedge clock) begin
      utf8sd_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: code_point %h bad %b last %b",
                           rsp_code_point, rsp_bad_sequence, rsp_last_of_run);
            end else begin
               want = expected_results.pop_front();
               if (rsp_code_point !== want.code_point ||
                   rsp_bad_sequence !== want.bad_sequence ||
                   rsp_last_of_run !== want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                              want.code_point, want.bad_sequence, want.last_of_run,
                              rsp_code_point, rsp_bad_sequence, rsp_last_of_run);
               end
            end
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // long receiver hold-off so that the block fills and stalls its input
   initial begin
      wait (accepted_count >= HOLD_START);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL utf8_stream_decoder");
         $finish;
      end
   end

   // end of run: drain, settle, report
   initial begin
      wait (total_bytes != 0);
      while (accepted_count < total_bytes) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS utf8_stream_decoder");
      end else begin
         $display("FAIL utf8_stream_decoder");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_decode.sv
hw/rtl/utf8sd_queue.sv
hw/rtl/utf8_stream_decoder.sv
tb/testbench.sv
